@@ design/periodic_task_tick_scheduler_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the periodic task tick scheduler
// Shared immediate-style wrappers around concurrent property checks.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_SCHEDULER_UNIT_MACROS_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ptts: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ptts: next-cycle check failed");

`endif

@@ design/ptts_pkg.sv @@
// ---------------------------------------------------------------------------
// ptts_pkg
// Types and constants shared by the periodic task tick scheduler.
// ---------------------------------------------------------------------------
package ptts_pkg;

	localparam int TASK_SLOTS_DEF = 8;
	localparam int CMD_W          = 3;
	localparam int IDX_W          = 3;
	localparam int TIME_W         = 16;
	localparam int MASK_W         = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 3'd0,
		CMD_CREATE  = 3'd1,
		CMD_DELETE  = 3'd2,
		CMD_SUSPEND = 3'd3,
		CMD_RESUME  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] countdown;
	} slot_entry_t;

endpackage

@@ design/ptts_cmd_if.sv @@
// ---------------------------------------------------------------------------
// ptts_cmd_if
// Command channel: valid/ready handshake with one scheduler command.
// ---------------------------------------------------------------------------
interface ptts_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [ptts_pkg::CMD_W-1:0]       cmd;
	logic [ptts_pkg::IDX_W-1:0]       task_index;
	logic [ptts_pkg::TIME_W-1:0]      period;
	logic [ptts_pkg::TIME_W-1:0]      first_delay;

	modport source (output valid, output cmd, output task_index, output period,
		output first_delay, input ready);
	modport sink (input valid, input cmd, input task_index, input period,
		input first_delay, output ready);
endinterface

@@ design/ptts_res_if.sv @@
// ---------------------------------------------------------------------------
// ptts_res_if
// Result channel: valid/ready handshake with one scheduler result.
// ---------------------------------------------------------------------------
interface ptts_res_if;
	logic                         valid;
	logic                         ready;
	logic                         create_failed;
	logic [ptts_pkg::MASK_W-1:0]  fire_mask;

	modport source (output valid, output create_failed, output fire_mask, input ready);
	modport sink (input valid, input create_failed, input fire_mask, output ready);
endinterface

@@ design/periodic_task_tick_scheduler_unit.sv @@
// ---------------------------------------------------------------------------
// periodic_task_tick_scheduler_unit
// Priority-indexed task slot table with create/delete/suspend/resume/tick.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one command transaction (cmd, task_index, period, first_delay)
//   and rsp returns exactly one result transaction per command
//   (create_failed, fire_mask). Both use valid/ready.
//   Create, delete, suspend, resume and unused codes finish in the accept
//   cycle; their result is valid in the next cycle.
//   A tick walks the slot table through the slot memory read port, one slot
//   per cycle, with the read-modify-write pipelined one slot behind. The
//   single read port of the slot memory sets the pace of the walk.
//   Only one command is in flight: req.ready is high in the idle state while
//   the result register is empty or being drained in the same cycle. With no
//   stall, a non-tick command can be taken every cycle; after a tick, no new
//   command is taken until the walk is over and its result is loaded.
//   A stalled rsp holds its result; the block then takes no new command.
//   Reset clears the valid and suspended marks and the control state; the
//   period/countdown memory is not cleared and needs no pass, since an
//   entry is always written by create before its slot can fire.
// ---------------------------------------------------------------------------
module periodic_task_tick_scheduler_unit #(
	parameter int TASK_SLOTS = ptts_pkg::TASK_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ptts_cmd_if.sink    req,
	ptts_res_if.source  rsp
);

	localparam int SLOT_AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int EXT_W   = (SLOT_AW > ptts_pkg::IDX_W) ? SLOT_AW : ptts_pkg::IDX_W;
	localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(TASK_SLOTS - 1);

	// control state
	ptts_pkg::state_t state_q, state_d;
	logic [SLOT_AW-1:0] rd_ptr_q;
	logic [TASK_SLOTS-1:0] slot_valid_q;
	logic [TASK_SLOTS-1:0] slot_susp_q;
	logic [ptts_pkg::MASK_W-1:0] mask_q;

	// walk pipeline
	logic               walk_vld_s1;
	logic [SLOT_AW-1:0] idx_s1;

	// result register
	logic                        rsp_valid_q;
	logic                        create_failed_q;
	logic [ptts_pkg::MASK_W-1:0] fire_mask_q;

	// FSM outputs
	logic ready_o;
	logic rd_en;
	logic done_load;

	// decode of the incoming transaction
	ptts_pkg::cmd_t     cmd;
	logic [EXT_W-1:0]   idx_ext;
	logic [SLOT_AW-1:0] slot_addr;
	logic               in_range;
	logic               accept;
	logic               out_free;
	logic               cmd_load;
	logic               create_fail;

	// memory ports
	logic                  mem_we;
	logic [SLOT_AW-1:0]    mem_waddr;
	ptts_pkg::slot_entry_t mem_wdata;
	ptts_pkg::slot_entry_t mem_rdata;

	// slot update at stage 1
	logic cd_zero;
	logic slot_susp;
	logic slot_vld;
	logic fire;
	logic wb_en;
	ptts_pkg::slot_entry_t wb_entry;

	assign cmd       = ptts_pkg::cmd_t'(req.cmd);
	assign idx_ext   = EXT_W'(req.task_index);
	assign slot_addr = idx_ext[SLOT_AW-1:0];
	assign in_range  = ({1'b0, idx_ext} < (EXT_W + 1)'(TASK_SLOTS));
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && ready_o;
	assign cmd_load  = accept && (cmd != ptts_pkg::CMD_TICK);
	// refuse create on a taken slot or one past the table
	assign create_fail = (cmd == ptts_pkg::CMD_CREATE) &&
		(!in_range || slot_valid_q[slot_addr]);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptts_pkg::S_IDLE: begin
				if (accept && (cmd == ptts_pkg::CMD_TICK)) begin
					state_d = ptts_pkg::S_WALK;
				end
			end
			ptts_pkg::S_WALK: begin
				if (rd_ptr_q == LAST_SLOT) begin
					state_d = ptts_pkg::S_DRAIN;
				end
			end
			ptts_pkg::S_DRAIN: begin
				state_d = ptts_pkg::S_DONE;
			end
			ptts_pkg::S_DONE: begin
				if (out_free) begin
					state_d = ptts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ptts_pkg::S_IDLE;
			end
		endcase
	end

	// FSM outputs
	always_comb begin
		ready_o   = 1'b0;
		rd_en     = 1'b0;
		done_load = 1'b0;
		case (state_q)
			ptts_pkg::S_IDLE:  ready_o   = out_free;
			ptts_pkg::S_WALK:  rd_en     = 1'b1;
			ptts_pkg::S_DRAIN: ;
			ptts_pkg::S_DONE:  done_load = out_free;
			default: ;
		endcase
	end

	assign req.ready = ready_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// advance the read pointer through the table during a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			walk_vld_s1 <= 1'b0;
		end else begin
			walk_vld_s1 <= rd_en;
			if (accept) begin
				rd_ptr_q <= '0;
			end else if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + SLOT_AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= rd_ptr_q;
		end
	end

	// valid and suspended marks live in flops so reset clears them at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			slot_susp_q  <= '0;
		end else if (accept && in_range) begin
			case (cmd)
				ptts_pkg::CMD_CREATE: begin
					if (!slot_valid_q[slot_addr]) begin
						slot_valid_q[slot_addr] <= 1'b1;
						slot_susp_q[slot_addr]  <= 1'b0;
					end
				end
				ptts_pkg::CMD_DELETE:  slot_valid_q[slot_addr] <= 1'b0;
				ptts_pkg::CMD_SUSPEND: slot_susp_q[slot_addr]  <= 1'b1;
				ptts_pkg::CMD_RESUME:  slot_susp_q[slot_addr]  <= 1'b0;
				default: ;
			endcase
		end
	end

	// stage 1: modify the entry read in the previous cycle
	assign cd_zero   = (mem_rdata.countdown == '0);
	assign slot_susp = slot_susp_q[idx_s1];
	assign slot_vld  = slot_valid_q[idx_s1];
	assign fire      = walk_vld_s1 && !slot_susp && cd_zero && slot_vld;
	// an invalid slot at zero stays at zero: skip the write
	assign wb_en     = walk_vld_s1 && !slot_susp && (!cd_zero || slot_vld);

	always_comb begin
		wb_entry.period    = mem_rdata.period;
		wb_entry.countdown = cd_zero ? (mem_rdata.period - ptts_pkg::TIME_W'(1))
			: (mem_rdata.countdown - ptts_pkg::TIME_W'(1));
	end

	// one write port: create in idle, write-back during a tick, never both
	always_comb begin
		if (wb_en) begin
			mem_we    = 1'b1;
			mem_waddr = idx_s1;
			mem_wdata = wb_entry;
		end else begin
			mem_we           = accept && (cmd == ptts_pkg::CMD_CREATE) && !create_fail;
			mem_waddr        = slot_addr;
			mem_wdata.period    = req.period;
			mem_wdata.countdown = req.first_delay;
		end
	end

	ptts_slot_ram #(
		.DEPTH (TASK_SLOTS),
		.AW    (SLOT_AW)
	) u_slot_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (rd_en),
		.raddr (rd_ptr_q),
		.rdata (mem_rdata)
	);

	// collect fired slots; slots beyond the mask width shift out
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q <= '0;
		end else if (fire) begin
			mask_q <= mask_q | (ptts_pkg::MASK_W'(1) << idx_s1);
		end
	end

	// result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd_load || done_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_load) begin
			create_failed_q <= create_fail;
			fire_mask_q     <= '0;
		end else if (done_load) begin
			create_failed_q <= 1'b0;
			fire_mask_q     <= mask_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.create_failed = create_failed_q;
	assign rsp.fire_mask     = fire_mask_q;

endmodule

@@ design/ptts_slot_ram.sv @@
// ---------------------------------------------------------------------------
// ptts_slot_ram
// Slot table memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ptts_slot_ram #(
	parameter int DEPTH = ptts_pkg::TASK_SLOTS_DEF,
	parameter int AW    = 3
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  ptts_pkg::slot_entry_t wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output ptts_pkg::slot_entry_t rdata
);

	ptts_pkg::slot_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/ptts_checker.sv @@
// ---------------------------------------------------------------------------
// ptts_checker
// Port-level checks of the scheduler: one result per command, held stalls.
// ---------------------------------------------------------------------------
`include "periodic_task_tick_scheduler_unit_macros.svh"

module ptts_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        create_failed,
	input logic [ptts_pkg::MASK_W-1:0] fire_mask
);

	logic req_acc;
	logic rsp_acc;
	logic pending_q;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// track one command in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (req_acc) begin
			pending_q <= 1'b1;
		end else if (rsp_acc) begin
			pending_q <= 1'b0;
		end
	end

	`PTTS_ASSERT_SAME(a_no_orphan_result, clk, arst_n, rsp_valid, pending_q)
	`PTTS_ASSERT_SAME(a_one_in_flight, clk, arst_n, req_acc, (!pending_q || rsp_acc))
	`PTTS_ASSERT_SAME(a_fail_has_no_fire, clk, arst_n, (rsp_valid && create_failed),
		(fire_mask == '0))
	`PTTS_ASSERT_NEXT(a_stall_holds, clk, arst_n, (rsp_valid && !rsp_ready),
		(rsp_valid && $stable(fire_mask) && $stable(create_failed)))

endmodule

bind periodic_task_tick_scheduler_unit ptts_checker u_ptts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.create_failed (rsp.create_failed),
	.fire_mask     (rsp.fire_mask)
);

@@ test/tb_periodic_task_tick_scheduler_unit.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler_unit
// Drives scheduler commands through the request channel and checks every
// response against a cycle-free scheduler predictor kept in the bench.
// A directed opening fills the slot table and walks the corner cases, then
// a long random mix of ticks and slot commands runs with bursty requests
// and a response side that stalls on its own pattern.
// ---------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler_unit;
	import ptts_pkg::*;

	localparam int SLOTS        = TASK_SLOTS_DEF;
	localparam int RANDOM_CMDS  = 1200;
	localparam int HOLDOFF_LEN  = 150;	// cycles of forced response stall
	localparam int HOLDOFF_STEP = 500;	// accepted commands between hold-offs
	localparam int SETTLE_CYCLES = SLOTS + 4;

	// Command codes the block does not define; they must come back empty.
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

	typedef enum int {
		FLOW_FREE,
		FLOW_RANDOM,
		FLOW_PULSED
	} flow_mode_t;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [IDX_W-1:0]  task_index;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] first_delay;
	} sched_cmd_t;

	typedef struct {
		logic [CMD_W-1:0]  cmd;		// kept for messages only
		logic              create_failed;
		logic [MASK_W-1:0] fire_mask;
	} sched_outcome_t;

	logic clk;
	logic arst_n;

	ptts_cmd_if req_if ();
	ptts_res_if rsp_if ();

	periodic_task_tick_scheduler_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Shadow of the slot table.
	bit                slot_live   [SLOTS];
	bit                slot_parked [SLOTS];
	logic [TIME_W-1:0] slot_reload [SLOTS];
	logic [TIME_W-1:0] slot_count  [SLOTS];

	sched_cmd_t     command_backlog[$];
	sched_outcome_t pending_outcomes[$];

	int         total_cmds;
	int         accepted_cmds;
	int         fault_count;
	logic       cmd_taken;

	int         burst_left;
	int         gap_left;
	sched_cmd_t next_cmd;

	int         hold_left;
	int         next_hold_at;
	int         phase_left;
	flow_mode_t flow_mode;
	logic       ready_next;

	sched_outcome_t got;
	sched_outcome_t want;
	sched_cmd_t     seen_cmd;

	// Clock: 8 ns period.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Apply one command to the shadow table and return the response it owes.
	function automatic sched_outcome_t run_scheduler_command(input sched_cmd_t c);
		sched_outcome_t o;
		o.cmd           = c.cmd;
		o.create_failed = 1'b0;
		o.fire_mask     = '0;
		case (c.cmd)
			CMD_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!slot_parked[i]) begin
						if (slot_count[i] == '0) begin
							// Only a live slot fires; a dead one sits at zero.
							if (slot_live[i]) begin
								if (i < MASK_W)
									o.fire_mask[i] = 1'b1;
								slot_count[i] = slot_reload[i] - 1'b1;
							end
						end else begin
							slot_count[i] = slot_count[i] - 1'b1;
						end
					end
				end
			end
			CMD_CREATE: begin
				if (c.task_index >= SLOTS || slot_live[c.task_index]) begin
					o.create_failed = 1'b1;
				end else begin
					slot_live[c.task_index]   = 1'b1;
					slot_parked[c.task_index] = 1'b0;
					slot_reload[c.task_index] = c.period;
					slot_count[c.task_index]  = c.first_delay;
				end
			end
			CMD_DELETE: begin
				// Only the live mark goes; the parked mark and timers stay.
				if (c.task_index < SLOTS)
					slot_live[c.task_index] = 1'b0;
			end
			CMD_SUSPEND: begin
				if (c.task_index < SLOTS)
					slot_parked[c.task_index] = 1'b1;
			end
			CMD_RESUME: begin
				if (c.task_index < SLOTS)
					slot_parked[c.task_index] = 1'b0;
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int idx,
		input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] dly);
		sched_cmd_t c;
		c.cmd         = cmd;
		c.task_index  = idx[IDX_W-1:0];
		c.period      = per;
		c.first_delay = dly;
		command_backlog.push_back(c);
	endtask

	// Stimulus: hold reset, load the backlog, then wait for the block to drain.
	initial begin
		int pick;
		sched_cmd_t c;

		arst_n            = 1'b0;
		req_if.valid      = 1'b0;
		req_if.cmd        = '0;
		req_if.task_index = '0;
		req_if.period     = '0;
		req_if.first_delay = '0;
		rsp_if.ready      = 1'b0;

		// Fill every slot first so that no tick ever walks a timer entry
		// that was never written.
		queue_cmd(CMD_CREATE, 0, 16'd1, 16'd0);		// fires on every tick
		queue_cmd(CMD_CREATE, 1, 16'd0, 16'd0);		// zero period: reload wraps to all ones
		queue_cmd(CMD_CREATE, 2, 16'hFFFF, 16'hFFFF);	// longest period and delay
		queue_cmd(CMD_CREATE, 3, 16'd2, 16'd1);
		queue_cmd(CMD_CREATE, 4, 16'd3, 16'd2);
		queue_cmd(CMD_CREATE, 5, 16'hA5A5, 16'h5A5A);
		queue_cmd(CMD_CREATE, 6, 16'd4, 16'd0);
		queue_cmd(CMD_CREATE, 7, 16'd1, 16'd3);
		// Create on a taken slot must be refused without touching it.
		queue_cmd(CMD_CREATE, 3, 16'h1234, 16'h0000);
		queue_cmd(CMD_TICK, 0, 16'h0000, 16'h0000);
		queue_cmd(CMD_TICK, 7, 16'hFFFF, 16'hFFFF);
		// Park the highest-priority slot across one tick.
		queue_cmd(CMD_SUSPEND, 0, 16'd0, 16'd0);
		queue_cmd(CMD_TICK, 0, 16'd0, 16'd0);
		queue_cmd(CMD_RESUME, 0, 16'd0, 16'd0);
		// Suspend and resume on a deleted slot still write the mark.
		queue_cmd(CMD_DELETE, 6, 16'd0, 16'd0);
		queue_cmd(CMD_SUSPEND, 6, 16'd0, 16'd0);
		queue_cmd(CMD_TICK, 0, 16'd0, 16'd0);
		queue_cmd(CMD_RESUME, 6, 16'd0, 16'd0);
		queue_cmd(CMD_TICK, 0, 16'd0, 16'd0);
		// Delete leaves the parked mark; create clears it again.
		queue_cmd(CMD_SUSPEND, 7, 16'd0, 16'd0);
		queue_cmd(CMD_DELETE, 7, 16'd0, 16'd0);
		queue_cmd(CMD_CREATE, 7, 16'd2, 16'd0);
		queue_cmd(CMD_TICK, 0, 16'd0, 16'd0);
		// Undefined codes come back with an empty response.
		queue_cmd(CMD_SPARE_FIRST, 2, 16'hFFFF, 16'h0000);
		queue_cmd(CMD_SPARE_LAST, 5, 16'h0000, 16'hFFFF);

		// Random mix, weighted toward ticks with short periods so slots fire often.
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			pick          = $urandom_range(0, 99);
			c.task_index  = IDX_W'($urandom_range(0, SLOTS - 1));
			c.period      = TIME_W'($urandom());
			c.first_delay = TIME_W'($urandom());
			if (pick < 45) begin
				c.cmd = CMD_TICK;
			end else if (pick < 65) begin
				c.cmd = CMD_CREATE;
				// Mostly short timers, now and then the whole range.
				if ($urandom_range(0, 7) != 0)
					c.period = TIME_W'($urandom_range(0, 6));
				if ($urandom_range(0, 7) != 0)
					c.first_delay = TIME_W'($urandom_range(0, 8));
			end else if (pick < 75) begin
				c.cmd = CMD_DELETE;
			end else if (pick < 85) begin
				c.cmd = CMD_SUSPEND;
			end else if (pick < 95) begin
				c.cmd = CMD_RESUME;
			end else begin
				c.cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
			end
			command_backlog.push_back(c);
		end
		total_cmds = command_backlog.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every command to be taken and every response to come back.
		while (accepted_cmds < total_cmds)
			@(posedge clk);
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		// Let a stray late response show up before closing.
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Request driver: bursts of back-to-back commands with random gaps.
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_if.valid && !cmd_taken) begin
				// Hold the offered command until the block takes it.
			end else if (gap_left > 0) begin
				gap_left--;
				req_if.valid <= 1'b0;
			end else if (command_backlog.size() > 0) begin
				next_cmd = command_backlog.pop_front();
				req_if.cmd         <= next_cmd.cmd;
				req_if.task_index  <= next_cmd.task_index;
				req_if.period      <= next_cmd.period;
				req_if.first_delay <= next_cmd.first_delay;
				req_if.valid       <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					// Leave about a third of bursts with no gap at all.
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// Response side: changing stall pattern plus periodic long hold-offs that
	// back the block up into its request channel.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (accepted_cmds >= next_hold_at) begin
				hold_left    = HOLDOFF_LEN - 1;
				next_hold_at = next_hold_at + HOLDOFF_STEP;
				ready_next   = 1'b0;
			end else begin
				if (phase_left == 0) begin
					flow_mode  = flow_mode_t'($urandom_range(FLOW_FREE, FLOW_PULSED));
					phase_left = $urandom_range(16, 96);
				end
				phase_left--;
				case (flow_mode)
					FLOW_FREE:   ready_next = 1'b1;
					FLOW_RANDOM: ready_next = ($urandom_range(0, 3) != 0);
					default:     ready_next = (phase_left % 3 != 0);
				endcase
			end
			rsp_if.ready <= ready_next;
		end
	end

	// Monitor: predict on every accepted command, check every accepted response.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_taken     <= 1'b0;
			accepted_cmds <= 0;
			fault_count   = 0;
			burst_left    = 0;
			gap_left      = 0;
			hold_left     = 0;
			phase_left    = 0;
			flow_mode     = FLOW_FREE;
			next_hold_at  = HOLDOFF_STEP / 2;
			pending_outcomes.delete();
			for (int i = 0; i < SLOTS; i++) begin
				slot_live[i]   = 1'b0;
				slot_parked[i] = 1'b0;
				slot_reload[i] = '0;
				slot_count[i]  = '0;
			end
		end else begin
			cmd_taken <= req_if.valid && req_if.ready;

			// Check the response before queuing the new expectation.
			if (rsp_if.valid && rsp_if.ready) begin
				got.create_failed = rsp_if.create_failed;
				got.fire_mask     = rsp_if.fire_mask;
				if (pending_outcomes.size() == 0) begin
					$display("%0t: unexpected response, expected none, %s %b fire_mask %02h",
						$time, "actual create_failed", got.create_failed, got.fire_mask);
					fault_count++;
				end else begin
					want = pending_outcomes.pop_front();
					if (got.create_failed !== want.create_failed) begin
						$display("%0t: create_failed mismatch (cmd %0d), expected %b, actual %b",
							$time, want.cmd, want.create_failed, got.create_failed);
						fault_count++;
					end
					if (got.fire_mask !== want.fire_mask) begin
						$display("%0t: fire_mask mismatch (cmd %0d), expected %02h, actual %02h",
							$time, want.cmd, want.fire_mask, got.fire_mask);
						fault_count++;
					end
				end
			end

			if (req_if.valid && req_if.ready) begin
				seen_cmd.cmd         = req_if.cmd;
				seen_cmd.task_index  = req_if.task_index;
				seen_cmd.period      = req_if.period;
				seen_cmd.first_delay = req_if.first_delay;
				pending_outcomes.push_back(run_scheduler_command(seen_cmd));
				accepted_cmds <= accepted_cmds + 1;
			end
		end
	end

	// Watchdog: generous bound on the whole run.
	initial begin
		#2_500_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
